[design/imadec_pkg.sv]
`default_nettype none

package imadec_pkg;

   // configuration register indexes
   localparam logic CsrStartPredictor = 1'b0;
   localparam logic CsrStartIndex     = 1'b1;

   localparam int unsigned StepEntries = 89;
   localparam logic [6:0]  IdxMax      = 7'd88;

   // saturation limits on the widened predictor sum
   localparam logic signed [17:0] SumMax = 18'sd32767;
   localparam logic signed [17:0] SumMin = -18'sd32768;
   localparam logic signed [15:0] PredMax = 16'sh7FFF;
   localparam logic signed [15:0] PredMin = 16'sh8000;

   // nibble counts after saturation
   localparam logic [1:0] CountNone = 2'd0;
   localparam logic [1:0] CountOne  = 2'd1;
   localparam logic [1:0] CountTwo  = 2'd2;

   localparam logic [14:0] StepTable [0:StepEntries-1] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
      15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
      15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
      15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
      15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
      15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
      15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
      15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
      15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
      15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
      15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
      15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
      15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
      15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
      15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
      15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   // step index movement per code magnitude
   localparam logic signed [4:0] AdjTable [0:7] = '{
      -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
   };

endpackage

`default_nettype wire

[design/imadec_nibble.sv]
`default_nettype none

module imadec_nibble (
   input  logic signed [15:0] pred,
   input  logic [6:0]         idx,
   input  logic [3:0]         code,
   output logic signed [15:0] next_pred,
   output logic [6:0]         next_idx
);

   logic [6:0]         idx_safe;
   logic [14:0]        step;
   logic [15:0]        diff;
   logic signed [17:0] pred_wide;
   logic signed [17:0] diff_wide;
   logic signed [17:0] sum;
   logic signed [4:0]  adj;
   logic signed [7:0]  idx_sum;

   always_comb begin
      idx_safe = (idx > imadec_pkg::IdxMax) ? imadec_pkg::IdxMax : idx;
      step     = imadec_pkg::StepTable[idx_safe];

      // difference built from shifted copies of the step
      diff = {3'b000, step[14:3]}
           + (code[2] ? {1'b0, step} : 16'd0)
           + (code[1] ? {2'b00, step[14:1]} : 16'd0)
           + (code[0] ? {3'b000, step[14:2]} : 16'd0);

      pred_wide = {{2{pred[15]}}, pred};
      diff_wide = $signed({2'b00, diff});
      sum       = code[3] ? (pred_wide - diff_wide) : (pred_wide + diff_wide);

      if (sum > imadec_pkg::SumMax) begin
         next_pred = imadec_pkg::PredMax;
      end else if (sum < imadec_pkg::SumMin) begin
         next_pred = imadec_pkg::PredMin;
      end else begin
         next_pred = sum[15:0];
      end

      adj     = imadec_pkg::AdjTable[code[2:0]];
      idx_sum = $signed({1'b0, idx_safe}) + $signed({{3{adj[4]}}, adj});
      if (idx_sum < 8'sd0) begin
         next_idx = 7'd0;
      end else if (idx_sum > $signed({1'b0, imadec_pkg::IdxMax})) begin
         next_idx = imadec_pkg::IdxMax;
      end else begin
         next_idx = idx_sum[6:0];
      end
   end

endmodule

`default_nettype wire

[design/ima_adpcm_decoder.sv]
`default_nettype none

// channel   dir   ports                                            request / item
// req       in    req_valid req_ready req_code_byte req_nibble_count req_restart   one code byte
// rsp       out   rsp_valid rsp_ready rsp_sample rsp_last          one pcm sample
// csr       in    csr_we csr_index csr_wdata                       register write, no wait
//
// codes are decoded one at a time, low code first, while the output has room; a
// zero-count byte decodes nothing and gives no sample; the predictor and step
// index loop through the single nibble decoder
// synchronous reset clears predictor, step index, start registers and all valid flags
// rsp_ready low holds the sample in the result register; one further request waits
// in the request register while req_ready stays high until it is full

module ima_adpcm_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_code_byte,
   input  logic [1:0]         req_nibble_count,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);

   // configuration registers
   logic signed [15:0] start_pred_ff;
   logic [6:0]         start_idx_ff;

   // decoder state
   logic signed [15:0] pred_ff, pred_in;
   logic [6:0]         idx_ff, idx_in;

   // request register
   logic       hold_valid_ff, hold_valid_in;
   logic       hold_phase_ff, hold_phase_in;
   logic [7:0] hold_byte_ff;
   logic [1:0] hold_count_ff;
   logic       hold_restart_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff;
   logic               rsp_last_ff;

   logic               out_free;
   logic               fire;
   logic               is_last;
   logic               hold_done;
   logic               use_start;
   logic signed [15:0] base_pred;
   logic [6:0]         base_idx;
   logic [6:0]         start_idx_sat;
   logic [3:0]         code;
   logic signed [15:0] dec_pred;
   logic [6:0]         dec_idx;
   logic               req_fire;

   // start index above the table end loads as the last entry
   assign start_idx_sat = (start_idx_ff > imadec_pkg::IdxMax) ? imadec_pkg::IdxMax
                                                              : start_idx_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // a zero-count byte needs no room at the output
   assign fire      = hold_valid_ff &&
                      ((hold_count_ff == imadec_pkg::CountNone) || out_free);
   assign is_last   = hold_phase_ff || (hold_count_ff != imadec_pkg::CountTwo);
   assign hold_done = fire && is_last;
   assign req_ready = !hold_valid_ff || hold_done;
   assign req_fire  = req_valid && req_ready;

   // restart swaps in the start values before the first code of the byte
   assign use_start = hold_restart_ff && !hold_phase_ff;
   assign base_pred = use_start ? start_pred_ff : pred_ff;
   assign base_idx  = use_start ? start_idx_sat : idx_ff;
   assign code      = hold_phase_ff ? hold_byte_ff[7:4] : hold_byte_ff[3:0];

   imadec_nibble u_nibble (
      .pred      (base_pred),
      .idx       (base_idx),
      .code      (code),
      .next_pred (dec_pred),
      .next_idx  (dec_idx)
   );

   always_comb begin
      pred_in       = pred_ff;
      idx_in        = idx_ff;
      hold_valid_in = hold_valid_ff;
      hold_phase_in = hold_phase_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (fire) begin
         if (hold_count_ff == imadec_pkg::CountNone) begin
            // no code to decode, only the restart takes effect
            pred_in = base_pred;
            idx_in  = base_idx;
         end else begin
            pred_in      = dec_pred;
            idx_in       = dec_idx;
            rsp_valid_in = 1'b1;
         end
         hold_phase_in = !is_last;
         if (is_last) begin
            hold_valid_in = 1'b0;
         end
      end

      if (req_fire) begin
         hold_valid_in = 1'b1;
         hold_phase_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pred_ff <= '0;
         start_idx_ff  <= '0;
         pred_ff       <= '0;
         idx_ff        <= '0;
         hold_valid_ff <= 1'b0;
         hold_phase_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pred_ff       <= pred_in;
         idx_ff        <= idx_in;
         hold_valid_ff <= hold_valid_in;
         hold_phase_ff <= hold_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               imadec_pkg::CsrStartPredictor: start_pred_ff <= csr_wdata;
               imadec_pkg::CsrStartIndex:     start_idx_ff  <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         hold_byte_ff    <= req_code_byte;
         // a count of three decodes both codes
         hold_count_ff   <= (req_nibble_count == 2'd3) ? imadec_pkg::CountTwo
                                                       : req_nibble_count;
         hold_restart_ff <= req_restart;
      end
      if (fire && (hold_count_ff != imadec_pkg::CountNone)) begin
         rsp_sample_ff <= dec_pred;
         rsp_last_ff   <= is_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

   // step index never leaves the table
   assert property (@(posedge clock) disable iff (reset) idx_ff <= imadec_pkg::IdxMax)
      else $error("step index beyond table end");

   // second code only pending for a two-code byte
   assert property (@(posedge clock) disable iff (reset)
      hold_phase_ff |-> (hold_valid_ff && (hold_count_ff == imadec_pkg::CountTwo)))
      else $error("second code pending without a two-code byte");

   // a non-final sample always has its partner code still held
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (hold_valid_ff && hold_phase_ff))
      else $error("first sample without its second code pending");

   // a zero-count byte never produces a sample
   assert property (@(posedge clock) disable iff (reset)
      (fire && (hold_count_ff == imadec_pkg::CountNone) && !(rsp_valid_ff && !rsp_ready))
      |=> (rsp_valid_ff == $past(rsp_valid_ff && !rsp_ready)))
      else $error("sample produced from a zero-count byte");

endmodule

`default_nettype wire
